// ----- hdl/sitda_pkg.sv -----
// Shared constants and controller/datapath interface types for the decimal text converter.
`timescale 1ns / 1ps

package sitda_pkg;

	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 4;
	localparam int MAX_DIGITS = 10;
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int PROD_W     = 2 * VALUE_W;

	// floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
	localparam logic [VALUE_W-1:0] RECIP       = 32'hCCCC_CCCD;
	localparam int                 RECIP_SHIFT = 35;
	localparam int                 QUOT_W      = PROD_W - RECIP_SHIFT;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

	typedef struct packed {
		logic load;      // latch magnitude and sign of a new value
		logic step;      // one divide-by-ten step, store remainder digit
		logic out_sign;  // load '-' into the output register
		logic out_digit; // load next digit (most significant first)
	} cmd_t;

	typedef struct packed {
		logic neg;        // value being converted is negative
		logic quot_zero;  // current divide step leaves zero quotient
		logic last_digit; // one stored digit remains
	} stat_t;

endpackage

// ----- hdl/sitda_dp.sv -----
// Datapath: magnitude register, divide-by-ten step, digit store and output payload register.
`timescale 1ns / 1ps

module sitda_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [sitda_pkg::VALUE_W-1:0] value,
	input  sitda_pkg::cmd_t                      cmd,
	output sitda_pkg::stat_t                     stat,
	output logic        [sitda_pkg::CHAR_W-1:0]  character,
	output logic                                 last
);

	logic [sitda_pkg::VALUE_W-1:0] mag_q;
	logic                          neg_q;
	logic [sitda_pkg::CNT_W-1:0]   cnt_q;
	logic [sitda_pkg::DIGIT_W-1:0] digits_q [sitda_pkg::MAX_DIGITS];
	logic [sitda_pkg::CHAR_W-1:0]  char_q;
	logic                          last_q;

	logic [sitda_pkg::PROD_W-1:0]  prod;
	logic [sitda_pkg::QUOT_W-1:0]  quot;
	logic [sitda_pkg::QUOT_W-1:0]  quot_x10;
	logic [sitda_pkg::DIGIT_W-1:0] rem;
	logic [sitda_pkg::CNT_W-1:0]   rd_idx;
	logic [sitda_pkg::VALUE_W-1:0] in_raw;

	assign in_raw   = value;
	assign prod     = {{sitda_pkg::VALUE_W{1'b0}}, mag_q} *
	                  {{sitda_pkg::VALUE_W{1'b0}}, sitda_pkg::RECIP};
	assign quot     = prod[sitda_pkg::PROD_W-1:sitda_pkg::RECIP_SHIFT];
	assign quot_x10 = (quot << 3) + (quot << 1);
	// remainder is below ten, so the low bits suffice
	assign rem      = mag_q[sitda_pkg::DIGIT_W-1:0] - quot_x10[sitda_pkg::DIGIT_W-1:0];
	assign rd_idx   = cnt_q - 1'b1;

	assign stat.neg        = neg_q;
	assign stat.quot_zero  = (quot == '0);
	assign stat.last_digit = (cnt_q == sitda_pkg::CNT_W'(1));

	assign character = char_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q <= '0;
			neg_q <= in_raw[sitda_pkg::VALUE_W-1];
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.out_digit) begin
			cnt_q <= rd_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= in_raw[sitda_pkg::VALUE_W-1] ? (~in_raw + 1'b1) : in_raw;
		end else if (cmd.step) begin
			mag_q <= sitda_pkg::VALUE_W'(quot);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			digits_q[cnt_q] <= rem;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_sign) begin
			char_q <= sitda_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.out_digit) begin
			char_q <= sitda_pkg::CHAR_ZERO +
			          {{(sitda_pkg::CHAR_W - sitda_pkg::DIGIT_W){1'b0}}, digits_q[rd_idx]};
			last_q <= (cnt_q == sitda_pkg::CNT_W'(1));
		end
	end

endmodule

// ----- hdl/sitda_ctrl.sv -----
// Controller: sequences load, digit extraction and character emission, owns output valid.
`timescale 1ns / 1ps

module sitda_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  sitda_pkg::stat_t stat,
	output sitda_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   ov_q;
	logic   out_free;

	assign out_free  = !ov_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load      = in_valid;
			ST_CONV: cmd.step      = 1'b1;
			ST_SIGN: cmd.out_sign  = out_free;
			ST_EMIT: cmd.out_digit = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			if (cmd.out_sign || cmd.out_digit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (stat.quot_zero) state_q <= stat.neg ? ST_SIGN : ST_EMIT;
				end
				ST_SIGN: begin
					if (out_free) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free && stat.last_digit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/signed_int_to_decimal_ascii.sv -----
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
//  channel | signals                      | payload
//  --------+------------------------------+------------------------------
//  input   | in_valid / in_ready          | value[31:0] signed
//  output  | out_valid / out_ready        | character[7:0], last
//
// A value with D digits gets one load, D divide-by-ten steps on the shared
// reciprocal multiplier, a sign output for a negative value only, then D
// digit transfers. Output stalls hold the sequencer; the next value is taken
// while the final character still waits in the output register. Reset clears
// control state and the digit count and sign flag only.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sitda_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [sitda_pkg::CHAR_W-1:0]  character,
	output logic                                 last
);

	sitda_pkg::cmd_t  cmd;
	sitda_pkg::stat_t stat;

	sitda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sitda_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.stat      (stat),
		.character (character),
		.last      (last)
	);

endmodule

// ----- test/tb_signed_int_to_decimal_ascii.sv -----
// Testbench for signed_int_to_decimal_ascii: directed, drained and random values checked per character.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

	typedef struct packed {
		logic [sitda_pkg::CHAR_W-1:0] code;
		logic                         fin;
	} text_char_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 in_valid = 1'b0;
	logic                                 in_ready;
	logic signed [sitda_pkg::VALUE_W-1:0] value = '0;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	logic        [sitda_pkg::CHAR_W-1:0]  character;
	logic                                 last;

	text_char_t pending_text[$];
	int         errors = 0;
	bit         steady_flow = 1'b0;

	signed_int_to_decimal_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	// decimal text of one value, most significant digit first
	function automatic void predict_text(logic [sitda_pkg::VALUE_W-1:0] raw);
		logic [sitda_pkg::VALUE_W-1:0] mag;
		logic [sitda_pkg::DIGIT_W-1:0] digits[sitda_pkg::MAX_DIGITS];
		int                            nd;
		text_char_t                    tc;
		mag = raw[sitda_pkg::VALUE_W-1] ? (32'd0 - raw) : raw;
		nd = 0;
		do begin
			digits[nd] = sitda_pkg::DIGIT_W'(mag % 10);
			mag = mag / 10;
			nd++;
		end while (mag != 0 && nd < sitda_pkg::MAX_DIGITS);
		if (raw[sitda_pkg::VALUE_W-1]) begin
			tc.code = sitda_pkg::CHAR_MINUS;
			tc.fin = 1'b0;
			pending_text.push_back(tc);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			tc.code = sitda_pkg::CHAR_ZERO + 8'(digits[i]);
			tc.fin = (i == 0);
			pending_text.push_back(tc);
		end
	endfunction

	// valid stays high between back-to-back transfers unless a random idle gap is inserted outside steady flow
	task automatic send_value(input logic signed [sitda_pkg::VALUE_W-1:0] v);
		int gap;
		if (!steady_flow && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_text(v);
	endtask

	task automatic wait_for_text;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_text.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_text.size() == 0) begin
				$display("%0t: unexpected char expected none actual %0d last %0b",
					$time, character, last);
				errors++;
			end else begin
				if (character !== pending_text[0].code || last !== pending_text[0].fin) begin
					$display("%0t: mismatch expected char %0d last %0b actual char %0d last %0b",
						$time, pending_text[0].code, pending_text[0].fin, character, last);
					errors++;
				end
				void'(pending_text.pop_front());
			end
		end
	end

	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if (!steady_flow && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	task automatic test_directed;
		logic signed [31:0] corners[] = '{
			32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
			-32'sd101, 32'sd2147483647, 32'h8000_0000, -32'sd2147483647,
			32'sd1000000000, 32'sd999999999, -32'sd1000000000, -32'sd999999999,
			32'sd1234567890, -32'sd1234567890, 32'sd1073741824, 32'h5555_5555,
			32'hAAAA_AAAA, 32'sd7, -32'sd9
		};
		foreach (corners[i]) send_value(corners[i]);
	endtask

	task automatic test_drain_pause;
		send_value(-32'sd2147483648);
		send_value(32'sd42);
		wait_for_text();
		send_value(32'sd0);
		send_value(-32'sd5);
		wait_for_text();
	endtask

	task automatic test_random(input int n);
		logic signed [31:0] v;
		logic        [31:0] lo;
		logic        [31:0] hi;
		int                 d;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 2))
				0: v = $urandom;
				1: begin
					d = $urandom_range(1, 10);
					lo = (d == 1) ? 32'd0 : 32'd1;
					hi = 32'd9;
					for (int j = 1; j < d; j++) begin
						lo = lo * 10;
						hi = hi * 10 + 9;
					end
					if (d == 10) hi = 32'd2147483647;
					v = $urandom_range(hi, lo);
					if ($urandom_range(0, 1)) v = -v;
				end
				default: begin
					d = $urandom_range(0, 9);
					v = 1;
					for (int j = 0; j < d; j++) v = v * 10;
					v = v - $urandom_range(0, 1);
					if ($urandom_range(0, 1)) v = -v;
					if ($urandom_range(0, 15) == 0) v = 32'h8000_0000;
				end
			endcase
			send_value(v);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_pause();
		test_random(400);
		steady_flow = 1'b1;
		test_random(40);
		wait_for_text();
		repeat (40) @(posedge clk);
		if (pending_text.size() != 0) errors++;
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
